// File: sv/pkpu_pkg.sv
// Package for the PKCS#7 pad/unpad stream core.
// Holds the byte width, the mode and status codes and the control struct shared by the
// top level and the hold cells. No dependencies.
package pkpu_pkg;

   localparam int BYTE_W = 8;

   // Mode register codes.
   localparam logic MODE_PAD   = 1'b0;
   localparam logic MODE_UNPAD = 1'b1;

   // Status codes on the final transaction of a message.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Control handed from the sequencer to every hold cell in the chain.
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] pad;
   } cell_ctrl_type;

endpackage

// File: sv/pkpu_req_if.sv
// Request channel interface of the PKCS#7 pad/unpad stream core.
// Carries valid, ready and one message byte with its framing flags.
// Depends on pkpu_pkg for the byte width.
interface pkpu_req_if;
   logic                       valid;
   logic                       ready;
   logic [pkpu_pkg::BYTE_W-1:0] data_byte;
   logic                       has_byte;
   logic                       last;

   modport source (output valid, output data_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last,
                   output ready);
endinterface

// Response channel interface of the PKCS#7 pad/unpad stream core.
// Carries valid, ready, an output byte and the end-of-message status.
interface pkpu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pkpu_pkg::BYTE_W-1:0] out_byte;
   logic                       byte_valid;
   logic                       end_of_message;
   logic                       status;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_message, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_message, input status, output ready);
endinterface

// File: sv/pkpu_cell.sv
// One hold cell of the unpad chain: stores a byte and passes it on when the chain shifts.
// Also flags whether its byte breaks the pad when it lies inside the pad region.
// Depends on pkpu_pkg.
module pkpu_cell #(
   parameter int BLOCK_BYTES = 16,
   parameter int POS         = 0
) (
   input  logic                        clock,
   input  pkpu_pkg::cell_ctrl_type     ctrl,
   input  logic [pkpu_pkg::BYTE_W-1:0] shift_in,
   output logic [pkpu_pkg::BYTE_W-1:0] hold_out,
   output logic                        mismatch
);

   logic [pkpu_pkg::BYTE_W-1:0] byte_ff;
   logic [pkpu_pkg::BYTE_W-1:0] byte_in;
   logic                        in_pad;

   assign byte_in  = ctrl.shift ? shift_in : byte_ff;
   assign hold_out = byte_ff;

   // The cell is a pad byte when its distance from the newest cell is below the pad count.
   assign in_pad   = ({1'b0, ctrl.pad} + (pkpu_pkg::BYTE_W+1)'(POS))
                     >= (pkpu_pkg::BYTE_W+1)'(BLOCK_BYTES);
   assign mismatch = in_pad && (byte_ff != ctrl.pad);

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: sv/pkcs7_pad_unpad_stream_core.sv
// PKCS#7 pad/unpad stream core.
//
// req (sink): one transaction per message byte; has_byte marks a real byte and last ends
// the message, so a transaction with has_byte low and last high is a bare end marker.
// rsp (source): one transaction per output byte, plus the end-of-message transaction in
// unpad mode (in pad mode the last pad byte ends the message). csr_wen/csr_wdata write
// the mode bit while idle (0 pads, 1 checks and strips the pad); such a write also drops
// any partial message. Bytes stream at one transaction per cycle while the core is idle
// and the output register is free to take one, and leave through the output register.
// At the end of a message pad mode sends its pad bytes (1 to BLOCK_BYTES); unpad mode
// spends a check step, then, if the pad is good, sends each remaining data byte, and then
// the status transaction. req.ready is low during that burst. In unpad mode the newest
// BLOCK_BYTES bytes wait in a chain of hold cells; bytes of earlier blocks leave before
// the check, so a status of 1 tells the receiver to discard the message.
// Reset is synchronous: mode returns to padding, the message counters clear and the
// output register empties. When rsp.ready is low the output register holds its
// transaction and req.ready falls until it is taken.
// Depends on pkpu_pkg, pkpu_req_if, pkpu_rsp_if and pkpu_cell.
module pkcs7_pad_unpad_stream_core #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   pkpu_req_if.sink                     req,
   pkpu_rsp_if.source                   rsp,
   input  logic                         csr_wen,
   input  logic                         csr_wdata
);

   localparam int BW    = pkpu_pkg::BYTE_W;
   localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
   localparam int PH_W  = $clog2(BLOCK_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                seen_ff, seen_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [BW-1:0]       pad_val_ff, pad_val_in;
   logic                ok_ff, ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]       out_byte_ff, out_byte_in;
   logic                byte_valid_ff, byte_valid_in;
   logic                eom_ff, eom_in;
   logic                status_ff, status_in;

   pkpu_pkg::cell_ctrl_type cell_ctrl;
   logic [BW-1:0]           tail_byte;
   logic [BW-1:0]           hold [BLOCK_BYTES];
   logic [BLOCK_BYTES-1:0]  mism;

   logic            slot_free;
   logic            accept;
   logic [PH_W-1:0] phase_next;
   logic [BW-1:0]   newest;
   logic            pad_in_range;

   genvar gi;
   generate
      for (gi = 0; gi < BLOCK_BYTES; gi++) begin : g_chain
         logic [BW-1:0] shift_src;
         if (gi == BLOCK_BYTES - 1) begin : g_tail
            assign shift_src = tail_byte;
         end else begin : g_body
            assign shift_src = hold[gi+1];
         end
         pkpu_cell #(
            .BLOCK_BYTES (BLOCK_BYTES),
            .POS         (gi)
         ) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .shift_in (shift_src),
            .hold_out (hold[gi]),
            .mismatch (mism[gi])
         );
      end
   endgenerate

   assign slot_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req.valid && req.ready;
   assign phase_next = (phase_ff == PH_W'(BLOCK_BYTES - 1)) ? '0 : phase_ff + 1'b1;
   assign newest     = hold[BLOCK_BYTES-1];
   assign pad_in_range = (newest != '0) && ({1'b0, newest} <= (BW+1)'(BLOCK_BYTES));

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      seen_in       = seen_ff;
      left_in       = left_ff;
      pad_val_in    = pad_val_ff;
      ok_in         = ok_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      eom_in        = eom_ff;
      status_in     = status_ff;
      tail_byte     = req.data_byte;
      cell_ctrl.shift = 1'b0;
      cell_ctrl.pad   = newest;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_wen) begin
               mode_in  = csr_wdata;
               count_in = '0;
               phase_in = '0;
               seen_in  = 1'b0;
            end else if (accept) begin
               if (req.has_byte) begin
                  phase_in = phase_next;
                  seen_in  = 1'b1;
                  if (mode_ff == pkpu_pkg::MODE_PAD) begin
                     rsp_valid_in  = 1'b1;
                     out_byte_in   = req.data_byte;
                     byte_valid_in = 1'b1;
                     eom_in        = 1'b0;
                     status_in     = pkpu_pkg::STATUS_OK;
                  end else begin
                     cell_ctrl.shift = 1'b1;
                     if (count_ff == CNT_W'(BLOCK_BYTES)) begin
                        // The oldest held byte falls out of the chain as the new one enters.
                        rsp_valid_in  = 1'b1;
                        out_byte_in   = hold[0];
                        byte_valid_in = 1'b1;
                        eom_in        = 1'b0;
                        status_in     = pkpu_pkg::STATUS_OK;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               if (req.last) begin
                  if (mode_ff == pkpu_pkg::MODE_PAD) begin
                     pad_val_in = BW'(BLOCK_BYTES) - BW'(req.has_byte ? phase_next : phase_ff);
                     left_in    = CNT_W'(BLOCK_BYTES)
                                  - CNT_W'(req.has_byte ? phase_next : phase_ff);
                     state_in   = ST_PAD;
                  end else begin
                     state_in   = ST_CHECK;
                  end
               end
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               out_byte_in   = pad_val_ff;
               byte_valid_in = 1'b1;
               eom_in        = (left_ff == CNT_W'(1));
               status_in     = pkpu_pkg::STATUS_OK;
               left_in       = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  count_in = '0;
                  phase_in = '0;
                  seen_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHECK: begin
            ok_in    = seen_ff && (phase_ff == '0) && (count_ff == CNT_W'(BLOCK_BYTES))
                       && pad_in_range && !(|mism);
            left_in  = CNT_W'(BLOCK_BYTES) - CNT_W'(newest);
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (ok_ff && (left_ff != '0)) begin
                  out_byte_in     = hold[0];
                  byte_valid_in   = 1'b1;
                  eom_in          = 1'b0;
                  status_in       = pkpu_pkg::STATUS_OK;
                  tail_byte       = '0;
                  cell_ctrl.shift = 1'b1;
                  left_in         = left_ff - 1'b1;
               end else begin
                  out_byte_in   = '0;
                  byte_valid_in = 1'b0;
                  eom_in        = 1'b1;
                  status_in     = ok_ff ? pkpu_pkg::STATUS_OK : pkpu_pkg::STATUS_BAD;
                  count_in      = '0;
                  phase_in      = '0;
                  seen_in       = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff       <= left_in;
      pad_val_ff    <= pad_val_in;
      ok_ff         <= ok_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      eom_ff        <= eom_in;
      status_ff     <= status_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_byte       = out_byte_ff;
   assign rsp.byte_valid     = byte_valid_ff;
   assign rsp.end_of_message = eom_ff;
   assign rsp.status         = status_ff;

endmodule

// File: sv/pkpu_checker.sv
// Port-level checker for the PKCS#7 pad/unpad stream core, with its bind statement.
// Watches only the response channel and the reset of the top level.
// Depends on pkpu_pkg and pkcs7_pad_unpad_stream_core.
module pkpu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pkpu_pkg::BYTE_W-1:0] out_byte,
   input logic                        byte_valid,
   input logic                        end_of_message,
   input logic                        status
);

   // A stalled transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(byte_valid)
                                  && $stable(end_of_message) && $stable(status))
      else $error("response changed while stalled");

   // The output register is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A failed check is reported only on a bare end-of-message transaction.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> end_of_message && !byte_valid)
      else $error("status set outside a final transaction");

   // A transaction without a byte is always the status transaction, with a zero byte.
   a_bare_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> end_of_message && (out_byte == '0))
      else $error("bare transaction that does not end the message");

endmodule

bind pkcs7_pad_unpad_stream_core pkpu_checker u_pkpu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .out_byte       (rsp.out_byte),
   .byte_valid     (rsp.byte_valid),
   .end_of_message (rsp.end_of_message),
   .status         (rsp.status)
);
